>>> src/mu8d_pkg.sv
package mu8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned PartW  = 20;
  localparam int unsigned CountW = 3;

  localparam logic [CountW-1:0] LenTwo   = 3'd2;
  localparam logic [CountW-1:0] LenThree = 3'd3;
  localparam logic [CountW-1:0] LenSix   = 3'd6;

  localparam logic [ByteW-1:0] SurrogateLead = 8'hED;
  localparam logic [CodeW-1:0] SuppBase      = 21'h10000;
  localparam logic [CodeW-1:0] MaxCodePoint  = 21'h10FFFF;

  typedef enum logic [1:0] {
    ST_CHAR     = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_TRUNC    = 2'd2
  } status_e;

endpackage

>>> src/modified_utf8_decoder.sv
// Modified UTF-8 / CESU-8 decoder.
// The input channel carries one encoded byte per beat together with an
// end-of-buffer flag on the last byte of each buffer. The output channel
// carries one decoded code point per beat, a status code and a finished
// flag set on the result of a buffer's last byte.
// Both channels use valid and stall; a beat moves on a rising edge with
// valid high and stall low.
// A beat is registered on acceptance and decoded from the input register.
// Its result, if it has one, is loaded into the output register when the
// output side takes the previous beat or is empty. One byte is accepted
// every cycle as long as the output side keeps taking results; bytes that
// open or continue a sequence without ending it give no output beat, and
// nor do dropped bytes. When the receiver stalls, the output register
// holds its beat and the input register keeps one more byte, after which
// the input stalls too. Reset clears both pipeline valid bits and the
// decoder state, so decoding starts at a lead byte with no open sequence.
module modified_utf8_decoder
  import mu8d_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             end_of_buffer_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CodeW-1:0] code_point_o,
  output logic [1:0]       status_o,
  output logic             finished_o
);

  logic              in_valid_q;
  logic [ByteW-1:0]  byte_q;
  logic              eob_q;

  logic [CountW-1:0] bytes_left_q, bytes_left_d;
  logic [CountW-1:0] seq_len_q, seq_len_d;
  logic [PartW-1:0]  partial_q, partial_d;
  logic              discard_q, discard_d;

  logic              out_valid_q;
  logic [CodeW-1:0]  code_point_q;
  status_e           status_q;
  logic              finished_q;

  logic              advance;
  logic              res_valid;
  logic [CodeW-1:0]  res_cp;
  status_e           res_st;
  logic              res_fin;
  logic [CountW-1:0] pos;
  logic [CountW-1:0] bytes_dec;
  logic [CountW-1:0] lead_len;
  logic [PartW-1:0]  lead_part;
  logic [PartW-1:0]  contrib;
  logic [PartW-1:0]  part_sum;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  assign pos       = seq_len_q - bytes_left_q;
  assign bytes_dec = bytes_left_q - 3'd1;
  assign part_sum  = partial_q + contrib;

  always_comb begin
    contrib = '0;
    case (seq_len_q)
      LenTwo: contrib = PartW'(byte_q[5:0]);
      LenThree: begin
        if (pos == 3'd1) begin
          contrib = PartW'({byte_q[5:0], 6'd0});
        end else begin
          contrib = PartW'(byte_q[5:0]);
        end
      end
      default: begin
        case (pos)
          3'd1:    contrib = PartW'({byte_q[3:0], 16'd0});
          3'd2:    contrib = PartW'({byte_q[5:0], 10'd0});
          3'd4:    contrib = PartW'({byte_q[3:0], 6'd0});
          3'd5:    contrib = PartW'(byte_q[5:0]);
          default: contrib = '0;
        endcase
      end
    endcase
  end

  always_comb begin
    if (byte_q[7:5] == 3'b110) begin
      lead_len  = LenTwo;
      lead_part = PartW'({byte_q[4:0], 6'd0});
    end else if (byte_q == SurrogateLead) begin
      lead_len  = LenSix;
      lead_part = '0;
    end else begin
      lead_len  = LenThree;
      lead_part = PartW'({byte_q[3:0], 12'd0});
    end
  end

  always_comb begin
    res_valid    = 1'b0;
    res_cp       = '0;
    res_st       = ST_CHAR;
    res_fin      = eob_q;
    bytes_left_d = bytes_left_q;
    seq_len_d    = seq_len_q;
    partial_d    = partial_q;
    discard_d    = discard_q;
    if (discard_q) begin
      if (eob_q) begin
        discard_d = 1'b0;
      end
    end else if (bytes_left_q == '0) begin
      if (!byte_q[7]) begin
        res_valid = 1'b1;
        res_cp    = CodeW'(byte_q);
      end else if (byte_q[7:6] == 2'b10 || byte_q[7:4] == 4'hF) begin
        res_valid = 1'b1;
        res_st    = ST_BAD_LEAD;
        discard_d = !eob_q;
      end else if (eob_q) begin
        res_valid = 1'b1;
        res_st    = ST_TRUNC;
        res_fin   = 1'b1;
      end else begin
        seq_len_d    = lead_len;
        bytes_left_d = lead_len - 3'd1;
        partial_d    = lead_part;
      end
    end else if (bytes_dec == '0) begin
      res_valid    = 1'b1;
      res_cp       = (seq_len_q == LenSix) ? CodeW'(part_sum) + SuppBase : CodeW'(part_sum);
      bytes_left_d = '0;
      seq_len_d    = '0;
      partial_d    = '0;
    end else if (eob_q) begin
      res_valid    = 1'b1;
      res_st       = ST_TRUNC;
      res_fin      = 1'b1;
      bytes_left_d = '0;
      seq_len_d    = '0;
      partial_d    = '0;
    end else begin
      bytes_left_d = bytes_dec;
      partial_d    = part_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= data_byte_i;
      eob_q  <= end_of_buffer_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      seq_len_q    <= '0;
      partial_q    <= '0;
      discard_q    <= 1'b0;
    end else if (in_valid_q && advance) begin
      bytes_left_q <= bytes_left_d;
      seq_len_q    <= seq_len_d;
      partial_q    <= partial_d;
      discard_q    <= discard_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && res_valid) begin
      code_point_q <= res_cp;
      status_q     <= res_st;
      finished_q   <= res_fin;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = code_point_q;
  assign status_o     = status_q;
  assign finished_o   = finished_q;

endmodule

>>> src/mu8d_checker.sv
module mu8d_checker
  import mu8d_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [CodeW-1:0] code_point_o,
  input logic [1:0]       status_o,
  input logic             finished_o
);

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_CHAR |-> code_point_o == '0)
    else $error("Error beat carries a nonzero code point.");

  a_trunc_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_TRUNC |-> finished_o)
    else $error("Truncated sequence beat is not marked finished.");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_CHAR || status_o == ST_BAD_LEAD ||
                     status_o == ST_TRUNC) && code_point_o <= MaxCodePoint)
    else $error("Output beat has an unknown status or an out-of-range code point.");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_point_o) &&
                                   $stable(status_o) && $stable(finished_o))
    else $error("Stalled output beat changed.");

  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("Input stalled while the output register is empty.");

endmodule

bind modified_utf8_decoder mu8d_checker u_mu8d_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .code_point_o (code_point_o),
  .status_o     (status_o),
  .finished_o   (finished_o)
);
